// ----- rtl/min_tracking_stack_defines.svh -----
// Assertion macros shared by the RTL of min_tracking_stack.
// Each macro expects clk and arst_n in scope.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// Combinational or implication property, checked outside reset.
`define MTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define MTS_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mts_pkg.sv -----
// Package for min_tracking_stack: sizes, opcode and state codes, result record.
// No dependencies.
package mts_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int DATA_W      = 32;
	localparam int ENTRY_W     = 11;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} opcode_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP_RD
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic                     underflow;
		logic                     overflow;
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] min_value;
		logic                     is_empty;
		logic [ENTRY_W-1:0]       entry_count;
	} result_t;

	// Fill count reduced (or widened) to the reported count width.
	function automatic logic [ENTRY_W-1:0] to_entry_count(input logic [CNT_W-1:0] c);
		logic [CNT_W+ENTRY_W-1:0] ext;
		ext = {{ENTRY_W{1'b0}}, c};
		return ext[ENTRY_W-1:0];
	endfunction

endpackage

// ----- rtl/mts_op_if.sv -----
// Operation channel of min_tracking_stack: valid/ready plus opcode and value.
// Depends on mts_pkg.
interface mts_op_if;
	import mts_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [0:0]               opcode;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink (input valid, input opcode, input push_value, output ready);
endinterface

// ----- rtl/mts_res_if.sv -----
// Result channel of min_tracking_stack: valid/ready plus the result fields.
// Depends on mts_pkg.
interface mts_res_if;
	import mts_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] popped_value;
	logic                     underflow;
	logic                     overflow;
	logic signed [DATA_W-1:0] top_value;
	logic signed [DATA_W-1:0] min_value;
	logic                     is_empty;
	logic [ENTRY_W-1:0]       entry_count;

	modport source (output valid, output popped_value, output underflow, output overflow,
		output top_value, output min_value, output is_empty, output entry_count,
		input ready);
	modport sink (input valid, input popped_value, input underflow, input overflow,
		input top_value, input min_value, input is_empty, input entry_count,
		output ready);
endinterface

// ----- rtl/mts_ram.sv -----
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
module mts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/min_tracking_stack.sv -----
// min_tracking_stack: bounded LIFO of signed words with running minimum.
// Depends on mts_pkg, mts_op_if, mts_res_if, mts_ram and min_tracking_stack_defines.svh.
//
// The top entry (value and running minimum) lives in flops; the entries below it
// live in one RAM of STACK_DEPTH-1 used rows, 64 bits wide (value, minimum). A push,
// an underflowing pop, a dropped push and a pop that leaves the stack empty have
// their result registered at the accepting edge. A pop that leaves entries behind
// passes through ST_POP_RD, since the new top comes from the registered RAM read;
// its result is registered as that state ends. A new operation is taken when no pop
// read is pending and the result register is free or transfers in the same cycle.
// No clearing pass is needed after reset.
module min_tracking_stack (
	input logic clk,
	input logic arst_n,
	mts_op_if.sink op,
	mts_res_if.source res
);
	import mts_pkg::*;
	`include "min_tracking_stack_defines.svh"

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic signed [DATA_W-1:0] top_val_q, top_val_d;
	logic signed [DATA_W-1:0] top_min_q, top_min_d;
	logic                     top_en;
	result_t                  res_q, res_d;
	logic                     res_valid_q;
	logic                     res_load;

	logic                     acc;
	logic                     empty, full;
	logic [CNT_W-1:0]         cnt_m1, cnt_m2, cnt_p1;
	logic signed [DATA_W-1:0] push_min;

	logic                     ram_we, ram_re;
	logic [2*DATA_W-1:0]      ram_rdata;
	logic signed [DATA_W-1:0] rd_val, rd_min;

	assign op.ready = (state_q == ST_IDLE) && (!res_valid_q || res.ready);
	assign acc      = op.valid && op.ready;

	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == CNT_W'(STACK_DEPTH));
	assign cnt_m1 = cnt_q - 1'b1;
	assign cnt_m2 = cnt_q - 2'd2;
	assign cnt_p1 = cnt_q + 1'b1;

	// Equal values take the pushed value; same bits either way.
	assign push_min = (!empty && (top_min_q < op.push_value)) ? top_min_q : op.push_value;

	assign rd_val = ram_rdata[2*DATA_W-1:DATA_W];
	assign rd_min = ram_rdata[DATA_W-1:0];

	// Old top moves into the RAM on push; the entry below the top is read on pop.
	mts_ram #(
		.WIDTH (2 * DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_m1[ADDR_W-1:0]),
		.wdata ({top_val_q, top_min_q}),
		.re    (ram_re),
		.raddr (cnt_m2[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		top_val_d = top_val_q;
		top_min_d = top_min_q;
		top_en    = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		res_load  = 1'b0;
		res_d     = '0;

		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (op.opcode == OP_PUSH) begin
						res_load = 1'b1;
						if (full) begin
							res_d.overflow    = 1'b1;
							res_d.top_value   = top_val_q;
							res_d.min_value   = top_min_q;
							res_d.entry_count = to_entry_count(cnt_q);
						end else begin
							ram_we            = !empty;
							cnt_d             = cnt_p1;
							top_en            = 1'b1;
							top_val_d         = op.push_value;
							top_min_d         = push_min;
							res_d.top_value   = op.push_value;
							res_d.min_value   = push_min;
							res_d.entry_count = to_entry_count(cnt_p1);
						end
					end else if (empty) begin
						res_load          = 1'b1;
						res_d.underflow   = 1'b1;
						res_d.is_empty    = 1'b1;
						res_d.entry_count = to_entry_count(cnt_q);
					end else if (cnt_m1 == '0) begin
						res_load           = 1'b1;
						cnt_d              = cnt_m1;
						res_d.popped_value = top_val_q;
						res_d.is_empty     = 1'b1;
						res_d.entry_count  = to_entry_count(cnt_m1);
					end else begin
						ram_re  = 1'b1;
						cnt_d   = cnt_m1;
						state_d = ST_POP_RD;
					end
				end
			end
			ST_POP_RD: begin
				// Result register is free here: it was drained or empty at accept.
				top_en             = 1'b1;
				top_val_d          = rd_val;
				top_min_d          = rd_min;
				res_load           = 1'b1;
				res_d.popped_value = top_val_q;
				res_d.top_value    = rd_val;
				res_d.min_value    = rd_min;
				res_d.entry_count  = to_entry_count(cnt_q);
				state_d            = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (top_en) begin
			top_val_q <= top_val_d;
			top_min_q <= top_min_d;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.popped_value = res_q.popped_value;
	assign res.underflow    = res_q.underflow;
	assign res.overflow     = res_q.overflow;
	assign res.top_value    = res_q.top_value;
	assign res.min_value    = res_q.min_value;
	assign res.is_empty     = res_q.is_empty;
	assign res.entry_count  = res_q.entry_count;

	`MTS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(STACK_DEPTH), "fill count above depth")
	`MTS_ASSERT_NEXT(a_pop_rd_one, state_q == ST_POP_RD, state_q == ST_IDLE,
		"pop read lasted more than one cycle")
	`MTS_ASSERT(a_pop_rd_free, (state_q != ST_POP_RD) || !res_valid_q,
		"result register busy during pop read")
	`MTS_ASSERT(a_min_le_top, empty || (state_q != ST_IDLE) || (top_min_q <= top_val_q),
		"tracked minimum above top value")
	`MTS_ASSERT_NEXT(a_full_hold, acc && (op.opcode == OP_PUSH) && full,
		cnt_q == CNT_W'(STACK_DEPTH), "dropped push changed the fill count")
endmodule
